/* hdl/pfba_pkg.sv */
// Package for the page frame bitmap allocator: shared constants, command and
// status codes, controller states and the run-search result struct.
// No dependencies; imported by pfba_run_scan and page_frame_bitmap_allocator.
`default_nettype none

package pfba_pkg;

  localparam int WORD_BITS      = 32;
  localparam int BIT_W          = 5;           // bit index inside one bitmap word
  localparam int MAX_FRAMES_DEF = 65536;
  localparam int FRAME_W        = 16;          // width of a frame number
  localparam int NEED_W         = 17;          // width of a page count
  localparam int TOTAL_W        = 17;          // width of the total_frames register
  localparam int LEN_W          = 18;          // width of a free-run length
  localparam int CNT_W          = 32;          // width of the allocation counter
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 17'd61440;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_TEST  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_ZERO_COUNT = 2'd1,
    STS_NO_SPACE   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FOUND,
    S_MARK,
    S_SINGLE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] idx;
    logic [LEN_W-1:0] carry;
  } scan_res_t;

endpackage

`default_nettype wire

/* hdl/pfba_run_scan.sv */
// Free-run search over one 32-bit bitmap word, continuing a run carried in
// from the words below. Depends on pfba_pkg.
`default_nettype none

module pfba_run_scan (
  input  wire logic [pfba_pkg::WORD_BITS-1:0] word,
  input  wire logic [pfba_pkg::LEN_W-1:0]     carry_in,
  input  wire logic [pfba_pkg::NEED_W-1:0]    need,
  output pfba_pkg::scan_res_t                 res
);
  import pfba_pkg::*;

  // Run length of free frames ending at each bit, built by doubling windows.
  logic [5:0]       lvl [0:5][0:WORD_BITS-1];
  logic [LEN_W-1:0] run_len [0:WORD_BITS-1];
  logic [WORD_BITS-1:0] hit_vec;
  logic [WORD_BITS-1:0] free_bits;

  assign free_bits = ~word;

  always_comb begin
    int s;
    int j;
    for (int i = 0; i < WORD_BITS; i++) begin
      lvl[0][i] = {5'd0, free_bits[i]};
    end
    for (int k = 0; k < 5; k++) begin
      s = 1 << k;
      for (int i = 0; i < WORD_BITS; i++) begin
        j = (i >= s) ? i - s : 0;
        if ((i >= s) && (lvl[k][i] == 6'(s))) begin
          lvl[k+1][i] = lvl[k][i] + lvl[k][j];
        end else begin
          lvl[k+1][i] = lvl[k][i];
        end
      end
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lvl[5][i] == 6'(i + 1)) begin
        run_len[i] = carry_in + LEN_W'(i + 1);
      end else begin
        run_len[i] = LEN_W'(lvl[5][i]);
      end
      hit_vec[i] = (run_len[i] >= {1'b0, need});
    end
  end

  always_comb begin
    res.hit   = |hit_vec;
    res.idx   = '0;
    res.carry = run_len[WORD_BITS-1];
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        res.idx = BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/page_frame_bitmap_allocator.sv */
// Top level of the page frame bitmap allocator: command sequencer, bitmap
// memory, allocation counter and result register. Depends on pfba_pkg and
// pfba_run_scan.
//
// Usage. Requests arrive on the in_ channel (valid/ready) and carry an
// opcode, a frame number and a page count. Each request produces exactly one
// result on the out_ channel (valid/ready): status, first frame of an
// allocated run, the test bit and the running allocation count.
// The used bits live in a one-port-read, one-port-write memory of
// MAX_FRAMES/32 words. After reset the block sweeps the memory to zero, one
// word per cycle; in_ready stays low until the sweep ends. The total_frames
// register resets to 61440 and may be written through cfg_wr_en/cfg_wr_data
// at any edge while the block is idle. Free, mark and test read the word,
// then modify/write it (test only reads it), then load the result; a frame
// number outside MAX_FRAMES skips the memory. Allocate reads the first word
// on acceptance, scans one word per cycle (up to total_frames/32, capped at
// the memory depth), finds the run start, marks each word the run touches
// with one read-modify-write per cycle, then loads the result; a zero page
// count or an empty search range goes straight to the result.
// One request is in flight at a time. A finished result waits in the output
// register while the next request is accepted; a new result is only loaded
// once the receiver has taken the previous one, so a stalled receiver
// eventually holds the block in its final step.
`default_nettype none

module page_frame_bitmap_allocator #(
  parameter int MAX_FRAMES = pfba_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [pfba_pkg::FRAME_W-1:0]  in_frame_number,
  input  wire logic [pfba_pkg::NEED_W-1:0]   in_page_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic [pfba_pkg::FRAME_W-1:0]       out_first_frame,
  output logic                               out_frame_used,
  output logic [pfba_pkg::CNT_W-1:0]         out_allocated_total,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pfba_pkg::TOTAL_W-1:0]  cfg_wr_data
);
  import pfba_pkg::*;

  localparam int WORDS = MAX_FRAMES / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int END_W = AW + BIT_W;

  // Bitmap memory: one used bit per frame.
  logic [WORD_BITS-1:0] bitmap_mem [0:WORDS-1];
  logic                 mem_re;
  logic [AW-1:0]        mem_ra;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [WORD_BITS-1:0] mem_wd;
  logic [WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= bitmap_mem[mem_ra];
    end
  end

  // Control and payload registers.
  state_t               state_r,  state_nxt;
  logic [AW-1:0]        clr_r,    clr_nxt;
  logic [TOTAL_W-1:0]   total_r,  total_nxt;
  logic [CNT_W-1:0]     cnt_r,    cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  opcode_t              op_r,     op_nxt;
  logic [FRAME_W-1:0]   frame_r,  frame_nxt;
  logic [NEED_W-1:0]    need_r,   need_nxt;
  logic [AW-1:0]        w_r,      w_nxt;
  logic [LEN_W-1:0]     cl_r,     cl_nxt;
  logic [END_W-1:0]     end_r,    end_nxt;
  logic [END_W-1:0]     start_r,  start_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [FRAME_W-1:0]   res_first_r,  res_first_nxt;
  logic                 res_used_r,   res_used_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [FRAME_W-1:0]   out_first_r,  out_first_nxt;
  logic                 out_used_r,   out_used_nxt;
  logic [CNT_W-1:0]     out_total_r,  out_total_nxt;

  // Search range in whole words, capped at the memory depth.
  logic [31:0] lim_words;
  always_comb begin
    lim_words = 32'(total_r) >> BIT_W;
    if (lim_words > 32'(WORDS)) begin
      lim_words = 32'(WORDS);
    end
  end

  // Run search over the word returned by the memory.
  scan_res_t scan_res;
  pfba_run_scan u_run_scan (
    .word     (rd_data_r),
    .carry_in (cl_r),
    .need     (need_r),
    .res      (scan_res)
  );

  // Address decode of the incoming frame number.
  logic [31:0]   in_word32;
  logic [AW-1:0] in_word;
  logic          in_in_range;
  assign in_word32   = {16'd0, in_frame_number} >> BIT_W;
  assign in_word     = in_word32[AW-1:0];
  assign in_in_range = ({16'd0, in_frame_number} < 32'(MAX_FRAMES));

  // Bit mask of the run inside the word being marked.
  logic [BIT_W-1:0]     mark_lo;
  logic [BIT_W-1:0]     mark_hi;
  logic [WORD_BITS-1:0] mark_mask;
  always_comb begin
    mark_lo   = (w_r == start_r[END_W-1:BIT_W]) ? start_r[BIT_W-1:0] : '0;
    mark_hi   = (w_r == end_r[END_W-1:BIT_W]) ? end_r[BIT_W-1:0] : '1;
    mark_mask = ({WORD_BITS{1'b1}} << mark_lo) &
                ({WORD_BITS{1'b1}} >> (5'd31 - mark_hi));
  end

  logic [WORD_BITS-1:0] frame_bit;
  assign frame_bit = {{(WORD_BITS-1){1'b0}}, 1'b1} << frame_r[BIT_W-1:0];

  logic [32:0] cnt_plus_need;
  logic [32:0] cnt_plus_one;
  logic [31:0] start32;
  assign cnt_plus_need = {1'b0, cnt_r} + 33'(need_r);
  assign cnt_plus_one  = {1'b0, cnt_r} + 33'd1;
  assign start32       = 32'(end_r) + 32'd1 - 32'(need_r);

  assign total_nxt = cfg_wr_en ? cfg_wr_data : total_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    frame_nxt      = frame_r;
    need_nxt       = need_r;
    w_nxt          = w_r;
    cl_nxt         = cl_r;
    end_nxt        = end_r;
    start_nxt      = start_r;
    res_status_nxt = res_status_r;
    res_first_nxt  = res_first_r;
    res_used_nxt   = res_used_r;
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_used_nxt   = out_used_r;
    out_total_nxt  = out_total_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    mem_re         = 1'b0;
    mem_ra         = '0;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    in_ready       = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = '0;
        clr_nxt = clr_r + AW'(1);
        if (32'(clr_r) == 32'(WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt         = opcode_t'(in_opcode);
          frame_nxt      = in_frame_number;
          need_nxt       = in_page_count;
          res_status_nxt = STS_OK;
          res_first_nxt  = '0;
          res_used_nxt   = 1'b0;
          if (opcode_t'(in_opcode) == OP_ALLOC) begin
            if (in_page_count == '0) begin
              res_status_nxt = STS_ZERO_COUNT;
              state_nxt      = S_FINISH;
            end else if (lim_words == 32'd0) begin
              res_status_nxt = STS_NO_SPACE;
              state_nxt      = S_FINISH;
            end else begin
              mem_re    = 1'b1;
              mem_ra    = '0;
              w_nxt     = '0;
              cl_nxt    = '0;
              state_nxt = S_SCAN;
            end
          end else if (in_in_range) begin
            mem_re    = 1'b1;
            mem_ra    = in_word;
            state_nxt = S_SINGLE;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_SCAN: begin
        // rd_data_r holds word w_r; the next word is fetched meanwhile.
        if (scan_res.hit) begin
          end_nxt   = {w_r, scan_res.idx};
          state_nxt = S_FOUND;
        end else if (32'(w_r) + 32'd1 == lim_words) begin
          res_status_nxt = STS_NO_SPACE;
          state_nxt      = S_FINISH;
        end else begin
          cl_nxt = scan_res.carry;
          w_nxt  = w_r + AW'(1);
          mem_re = 1'b1;
          mem_ra = w_r + AW'(1);
        end
      end

      S_FOUND: begin
        start_nxt     = start32[END_W-1:0];
        res_first_nxt = start32[FRAME_W-1:0];
        cnt_nxt       = cnt_plus_need[32] ? '1 : cnt_plus_need[31:0];
        w_nxt         = start32[END_W-1:BIT_W];
        mem_re        = 1'b1;
        mem_ra        = start32[END_W-1:BIT_W];
        state_nxt     = S_MARK;
      end

      S_MARK: begin
        // Write back word w_r with the run bits set while reading the next.
        mem_we = 1'b1;
        mem_wa = w_r;
        mem_wd = rd_data_r | mark_mask;
        if (w_r == end_r[END_W-1:BIT_W]) begin
          state_nxt = S_FINISH;
        end else begin
          w_nxt  = w_r + AW'(1);
          mem_re = 1'b1;
          mem_ra = w_r + AW'(1);
        end
      end

      S_SINGLE: begin
        mem_wa    = AW'({16'd0, frame_r} >> BIT_W);
        state_nxt = S_FINISH;
        unique case (op_r)
          OP_FREE: begin
            mem_we = 1'b1;
            mem_wd = rd_data_r & ~frame_bit;
          end
          OP_MARK: begin
            mem_we  = 1'b1;
            mem_wd  = rd_data_r | frame_bit;
            cnt_nxt = cnt_plus_one[32] ? '1 : cnt_plus_one[31:0];
          end
          OP_TEST: begin
            res_used_nxt = |(rd_data_r & frame_bit);
          end
          default: begin
          end
        endcase
      end

      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_first_nxt  = res_first_r;
          out_used_nxt   = res_used_r;
          out_total_nxt  = cnt_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      total_r     <= TOTAL_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    frame_r      <= frame_nxt;
    need_r       <= need_nxt;
    w_r          <= w_nxt;
    cl_r         <= cl_nxt;
    end_r        <= end_nxt;
    start_r      <= start_nxt;
    res_status_r <= res_status_nxt;
    res_first_r  <= res_first_nxt;
    res_used_r   <= res_used_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
    out_used_r   <= out_used_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_first_frame     = out_first_r;
  assign out_frame_used      = out_used_r;
  assign out_allocated_total = out_total_r;

  // A run chosen by the search must consist of free frames only.
  a_mark_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> ((rd_data_r & mark_mask) == '0))
    else $error("marking a frame that is already used");

  // The allocation count never goes down outside reset.
  a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (cnt_r >= $past(cnt_r)))
    else $error("allocation count decreased");

  // A result only appears at the end of a command.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside the finish step");

endmodule

`default_nettype wire
